### sv/pslb_pkg.sv
// Shared constants and types of the per-source leaky bucket limiter.
package pslb_pkg;

    localparam int unsigned NUM_ENTRIES_DEF = 256;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned BURST_W = 8;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned IDX_W = 2;

    localparam logic [BURST_W-1:0] ADDR_BURST_RST = 8'd10;
    localparam logic [PERIOD_W-1:0] ADDR_PERIOD_RST = 16'd1000;
    localparam logic [BURST_W-1:0] GLOBAL_BURST_RST = 8'd10;
    localparam logic [PERIOD_W-1:0] GLOBAL_PERIOD_RST = 16'd100;

    localparam logic [IDX_W-1:0] REG_ADDR_BURST = 2'd0;
    localparam logic [IDX_W-1:0] REG_ADDR_PERIOD = 2'd1;
    localparam logic [IDX_W-1:0] REG_GLOBAL_BURST = 2'd2;
    localparam logic [IDX_W-1:0] REG_GLOBAL_PERIOD = 2'd3;

    localparam logic [1:0] VERDICT_OK = 2'd0;
    localparam logic [1:0] VERDICT_FULL = 2'd1;
    localparam logic [1:0] VERDICT_ADDR = 2'd2;
    localparam logic [1:0] VERDICT_SHARED = 2'd3;

    // One bucket entry as it travels along the cell row
    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   addr;
        logic [TIME_W-1:0]   last_ms;
        logic [BURST_W-1:0]  count;
    } entry_t;

endpackage

### sv/pslb_if.sv
// Handshake channel interfaces of the limiter.
interface pslb_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] now_ms;
    modport source (output valid, src_addr, now_ms, input ready);
    modport sink (input valid, src_addr, now_ms, output ready);
endinterface

interface pslb_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] verdict;
    modport source (output valid, accepted, verdict, input ready);
    modport sink (input valid, accepted, verdict, output ready);
endinterface

interface pslb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/pslb_cell.sv
// One table cell: holds an entry and passes it to the next cell on rotate.
module pslb_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  pslb_pkg::entry_t  din,
    output pslb_pkg::entry_t  dout
);

    pslb_pkg::entry_t ent_reg;

    // Hold the entry, take the neighbor's on a rotate step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else if (shift)
        begin
            ent_reg <= din;
        end
    end

    assign dout = ent_reg;

endmodule

### sv/pslb_div.sv
// Restoring divider: 32-bit dividend by 16-bit divisor, one bit per cycle.
module pslb_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [31:0] quot,
    output logic [15:0] rem
);

    logic [31:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [5:0]  cnt_reg;
    logic [16:0] trial;
    logic [16:0] sub;

    assign trial = {r_reg[15:0], q_reg[31]};
    assign sub = trial - {1'b0, d_reg};

    // Shift one quotient bit in per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= (divisor == 16'd0) ? 16'd1 : divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (!sub[16])
            begin
                r_reg <= sub;
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != 6'd0);
    assign quot = q_reg;
    assign rem = r_reg[15:0];

endmodule

### sv/per_source_leaky_bucket_limiter_top.sv
// Top level of the per-source leaky bucket limiter.
//
//  channel | dir | payload                 | accepted when
//  req     | in  | src_addr, now_ms        | req.valid && req.ready
//  rsp     | out | accepted, verdict       | rsp.valid && rsp.ready
//  cfg     | in  | index, data             | cfg.valid && cfg.ready
//
// The table is a ring of NUM_ENTRIES cells that rotates one step per cycle
// during a lap. A request runs a search lap, on a miss a claim lap, then a
// leak division, a write-back lap and a shared division; a full table ends
// the request after the claim lap, and an address drop skips the shared
// division. Reset empties the table at once.
// A waiting result stalls only the acceptance of the next request.
module per_source_leaky_bucket_limiter_top
#(
    parameter int unsigned NUM_ENTRIES = pslb_pkg::NUM_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pslb_req_if.sink    req,
    pslb_rsp_if.source  rsp,
    pslb_cfg_if.sink    cfg
);

    localparam int unsigned CNT_W = $clog2(NUM_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PICK, S_ALEAK, S_AWAIT, S_ATAKE,
        S_GLEAK, S_GWAIT, S_GTAKE, S_OUT
    } state_t;

    state_t state_reg;

    logic [7:0]  abur_reg;
    logic [15:0] aper_reg;
    logic [7:0]  gbur_reg;
    logic [15:0] gper_reg;

    logic [31:0] addr_reg;
    logic [31:0] now_reg;
    logic [CNT_W-1:0] pos_reg;
    logic        found_reg;
    logic        claimed_reg;
    logic [CNT_W-1:0] hit_reg;
    logic [31:0] limit_reg;
    logic [31:0] last_reg;
    logic [7:0]  cnt_reg;
    logic [31:0] glast_reg;
    logic [7:0]  gcnt_reg;
    logic        acc_reg;
    logic [1:0]  verd_reg;
    logic        rsp_valid_reg;

    pslb_pkg::entry_t ring [NUM_ENTRIES];
    pslb_pkg::entry_t head_new;
    logic shift;

    logic        div_start;
    logic [31:0] div_dvd;
    logic [15:0] div_dvs;
    logic        div_busy;
    logic [31:0] div_q;
    logic [15:0] div_r;
    logic [31:0] diff;
    logic [31:0] hdiff;
    logic        head_expired;
    logic [7:0]  newcnt;
    logic [31:0] newlast;

    // Cell row: cell 0 takes the (possibly rewritten) head from the last cell
    genvar g;
    generate
        for (g = 0; g < NUM_ENTRIES; g++)
        begin : g_cell
            pslb_pkg::entry_t din;
            if (g == 0)
            begin : g_first
                assign din = head_new;
            end
            else
            begin : g_rest
                assign din = ring[g-1];
            end
            pslb_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (din),
                .dout  (ring[g])
            );
        end
    endgenerate

    pslb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Head of the ring is the last cell; the lap walks entries in index order
    pslb_pkg::entry_t head;
    assign head = ring[NUM_ENTRIES-1];
    assign hdiff = now_reg - head.last_ms;
    assign head_expired = hdiff[31] || (hdiff > limit_reg);

    // Rotate during each scan lap, including the commit lap that writes back the updated hit
    assign shift = (state_reg == S_SCAN);

    // Entry index of the head at each scan step equals pos_reg; the commit
    // lap writes the updated bucket into the hit or claimed entry
    always_comb
    begin
        head_new = head;
        if (state_reg == S_SCAN && commit_reg && hit_reg == pos_reg)
        begin
            head_new.valid = 1'b1;
            head_new.addr = addr_reg;
            head_new.last_ms = last_reg;
            head_new.count = cnt_reg;
        end
    end

    assign diff = now_reg - last_reg;

    // Leak result applied to the working bucket
    always_comb
    begin
        if (diff[31] || div_q > {24'd0, cnt_reg})
        begin
            newcnt = 8'd0;
            newlast = now_reg;
        end
        else
        begin
            newcnt = cnt_reg - div_q[7:0];
            newlast = now_reg - {16'd0, div_r};
        end
    end

    assign div_start = (state_reg == S_ALEAK) || (state_reg == S_GLEAK);
    assign div_dvd = (state_reg == S_ALEAK) ? diff : (now_reg - glast_reg);
    assign div_dvs = (state_reg == S_ALEAK) ? aper_reg : gper_reg;

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.accepted = acc_reg;
    assign rsp.verdict = verd_reg;

    logic [7:0] acnt_take;
    logic [7:0] gcnt_take;
    logic [31:0] gdiff;
    logic [7:0] gcnt_leak;
    logic [31:0] glast_leak;

    assign gdiff = now_reg - glast_reg;
    always_comb
    begin
        if (gdiff[31] || div_q > {24'd0, gcnt_reg})
        begin
            gcnt_leak = 8'd0;
            glast_leak = now_reg;
        end
        else
        begin
            gcnt_leak = gcnt_reg - div_q[7:0];
            glast_leak = now_reg - {16'd0, div_r};
        end
    end
    assign acnt_take = newcnt + 8'd1;
    assign gcnt_take = gcnt_leak + 8'd1;

    // Sequencer: search lap, leak, take, commit lap, shared bucket, result
    // Pass 1 finds a hit; a miss runs pass 2 to claim a free or expired entry
    logic pass2_reg;
    logic commit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            abur_reg <= pslb_pkg::ADDR_BURST_RST;
            aper_reg <= pslb_pkg::ADDR_PERIOD_RST;
            gbur_reg <= pslb_pkg::GLOBAL_BURST_RST;
            gper_reg <= pslb_pkg::GLOBAL_PERIOD_RST;
            glast_reg <= '0;
            gcnt_reg <= '0;
            found_reg <= 1'b0;
            claimed_reg <= 1'b0;
            pass2_reg <= 1'b0;
            commit_reg <= 1'b0;
            addr_reg <= '0;
            now_reg <= '0;
            limit_reg <= '0;
            pos_reg <= '0;
            hit_reg <= '0;
            last_reg <= '0;
            cnt_reg <= '0;
            acc_reg <= 1'b0;
            verd_reg <= pslb_pkg::VERDICT_OK;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    pslb_pkg::REG_ADDR_BURST:   abur_reg <= cfg.data[7:0];
                    pslb_pkg::REG_ADDR_PERIOD:  aper_reg <= cfg.data;
                    pslb_pkg::REG_GLOBAL_BURST: gbur_reg <= cfg.data[7:0];
                    pslb_pkg::REG_GLOBAL_PERIOD: gper_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        addr_reg <= req.src_addr;
                        now_reg <= req.now_ms;
                        limit_reg <= 32'(abur_reg) * 32'(aper_reg);
                        pos_reg <= '0;
                        found_reg <= 1'b0;
                        claimed_reg <= 1'b0;
                        pass2_reg <= 1'b0;
                        commit_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Search lap: capture hit; claim lap; commit lap
                    if (!commit_reg && !pass2_reg && !found_reg
                        && head.valid && head.addr == addr_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg <= pos_reg;
                        last_reg <= head.last_ms;
                        cnt_reg <= head.count;
                    end
                    if (!commit_reg && pass2_reg && !claimed_reg
                        && (!head.valid || head_expired))
                    begin
                        claimed_reg <= 1'b1;
                        hit_reg <= pos_reg;
                        last_reg <= now_reg;
                        cnt_reg <= 8'd0;
                    end
                    if (pos_reg == CNT_W'(NUM_ENTRIES - 1))
                    begin
                        pos_reg <= '0;
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + CNT_W'(1);
                    end
                end
                S_PICK:
                begin
                    if (commit_reg)
                    begin
                        state_reg <= S_GLEAK;
                    end
                    else if (found_reg || claimed_reg)
                    begin
                        state_reg <= S_ALEAK;
                    end
                    else if (!pass2_reg)
                    begin
                        pass2_reg <= 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        acc_reg <= 1'b0;
                        verd_reg <= pslb_pkg::VERDICT_FULL;
                        state_reg <= S_OUT;
                    end
                end
                S_ALEAK:
                begin
                    state_reg <= S_AWAIT;
                end
                S_AWAIT:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_ATAKE;
                    end
                end
                S_ATAKE:
                begin
                    // Apply the address bucket through a commit lap
                    last_reg <= newlast;
                    cnt_reg <= (newcnt < abur_reg) ? acnt_take : newcnt;
                    commit_reg <= 1'b1;
                    if (newcnt < abur_reg)
                    begin
                        acc_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg <= 1'b0;
                        verd_reg <= pslb_pkg::VERDICT_ADDR;
                    end
                    state_reg <= S_SCAN;
                end
                S_GLEAK:
                begin
                    state_reg <= acc_reg ? S_GWAIT : S_OUT;
                end
                S_GWAIT:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_GTAKE;
                    end
                end
                S_GTAKE:
                begin
                    glast_reg <= glast_leak;
                    if (gcnt_leak < gbur_reg)
                    begin
                        gcnt_reg <= gcnt_take;
                        verd_reg <= pslb_pkg::VERDICT_OK;
                    end
                    else
                    begin
                        gcnt_reg <= gcnt_leak;
                        acc_reg <= 1'b0;
                        verd_reg <= pslb_pkg::VERDICT_SHARED;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### test/per_source_leaky_bucket_limiter_top_tb.sv
// Testbench for the per-source leaky bucket limiter: directed table plus random traffic.
`timescale 1ns / 100ps

module per_source_leaky_bucket_limiter_top_tb;

    localparam int NENT = 256;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic        is_cfg;
        logic [1:0]  index;
        logic [15:0] data;
        logic [31:0] addr;
        logic [31:0] now;
        logic        known;
        logic [1:0]  verdict;
    } stim_row_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   error_count;
    int   hold_cycles;
    bit   quiet_phase;

    pslb_req_if req ();
    pslb_rsp_if rsp ();
    pslb_cfg_if cfg ();

    per_source_leaky_bucket_limiter_top #(.NUM_ENTRIES(NENT)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg(cfg.sink)
    );

    // Limiter state mirror
    logic [7:0]  lim_addr_burst;
    logic [15:0] lim_addr_period;
    logic [7:0]  lim_glob_burst;
    logic [15:0] lim_glob_period;
    logic        tab_valid [NENT];
    logic [31:0] tab_addr [NENT];
    logic [31:0] tab_last [NENT];
    logic [7:0]  tab_count [NENT];
    logic [31:0] glob_last;
    logic [7:0]  glob_count;

    logic [1:0]  verdict_queue [$];
    logic [31:0] address_pool [$];

    always #10 clk = ~clk;

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("per_source_leaky_bucket_limiter_top test failed");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Leak a bucket and try to take one credit
    function automatic bit bucket_pass(inout logic [31:0] last, inout logic [7:0] count,
                                       input logic [31:0] now, input logic [7:0] burst,
                                       input logic [15:0] period);
        logic [31:0] diff;
        logic [31:0] per;
        logic [31:0] leaked;
        logic [31:0] rem;
        diff = now - last;
        per = (period == 16'd0) ? 32'd1 : {16'd0, period};
        if (diff[31])
        begin
            count = 8'd0;
            last = now;
        end
        else
        begin
            leaked = diff / per;
            rem = diff % per;
            if (leaked > {24'd0, count})
            begin
                count = 8'd0;
                last = now;
            end
            else
            begin
                count = count - leaked[7:0];
                last = now - rem;
            end
        end
        if (count < burst)
        begin
            count = count + 8'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compute the verdict of one request and update the mirror
    function automatic logic [1:0] admit_verdict(input logic [31:0] addr, input logic [31:0] now);
        int slot;
        logic [31:0] span;
        logic [31:0] diff;
        slot = -1;
        for (int i = 0; i < NENT; i++)
            if (slot < 0 && tab_valid[i] && tab_addr[i] == addr)
                slot = i;
        if (slot < 0)
        begin
            span = {24'd0, lim_addr_burst} * {16'd0, lim_addr_period};
            for (int i = 0; i < NENT && slot < 0; i++)
            begin
                if (tab_valid[i])
                begin
                    diff = now - tab_last[i];
                    if (diff[31] || diff > span)
                    begin
                        tab_valid[i] = 1'b0;
                        tab_addr[i] = '0;
                        tab_last[i] = '0;
                        tab_count[i] = '0;
                    end
                end
                if (!tab_valid[i])
                begin
                    tab_valid[i] = 1'b1;
                    tab_addr[i] = addr;
                    tab_last[i] = now;
                    tab_count[i] = '0;
                    slot = i;
                end
            end
        end
        if (slot < 0)
            return pslb_pkg::VERDICT_FULL;
        if (!bucket_pass(tab_last[slot], tab_count[slot], now, lim_addr_burst, lim_addr_period))
            return pslb_pkg::VERDICT_ADDR;
        if (!bucket_pass(glob_last, glob_count, now, lim_glob_burst, lim_glob_period))
            return pslb_pkg::VERDICT_SHARED;
        return pslb_pkg::VERDICT_OK;
    endfunction

    // Result checker and receiver stall
    always @(posedge clk)
    begin
        logic [1:0] exp_v;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (verdict_queue.size() == 0)
                report("result with nothing expected");
            else
            begin
                exp_v = verdict_queue.pop_front();
                if (rsp.verdict !== exp_v)
                    report($sformatf("verdict %0d expected %0d", rsp.verdict, exp_v));
                if (rsp.accepted !== (exp_v == pslb_pkg::VERDICT_OK))
                    report($sformatf("accepted %0b for verdict %0d", rsp.accepted, exp_v));
            end
        end
    end

    initial
    begin
        int burst_left;
        rsp.ready = 0;
        burst_left = 0;
        @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready <= 0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                rsp.ready <= 0;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(0, 4);
                rsp.ready <= 0;
            end
            else
                rsp.ready <= 1;
        end
    end

    task automatic idle_gap();
        if (!quiet_phase && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 5)) @(negedge clk);
    endtask

    task automatic send_request(input logic [31:0] addr, input logic [31:0] now,
                                input logic known, input logic [1:0] want);
        logic [1:0] pred;
        idle_gap();
        req.valid <= 1'b1;
        req.src_addr <= addr;
        req.now_ms <= now;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pred = admit_verdict(addr, now);
        if (known && pred !== want)
            report($sformatf("table row expects %0d, prediction %0d", want, pred));
        verdict_queue = {verdict_queue, pred};
        @(negedge clk);
        req.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (verdict_queue.size() != 0)
            @(negedge clk);
        repeat (NENT + 100) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (index)
            pslb_pkg::REG_ADDR_BURST:    lim_addr_burst = data[7:0];
            pslb_pkg::REG_ADDR_PERIOD:   lim_addr_period = data;
            pslb_pkg::REG_GLOBAL_BURST:  lim_glob_burst = data[7:0];
            pslb_pkg::REG_GLOBAL_PERIOD: lim_glob_period = data;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        stim_row_t rows [$];
        logic [31:0] now;
        logic [31:0] addr;
        int phase_items;
        int pool_size;
        clk = 0;
        rst_n = 0;
        cycle_count = 0;
        error_count = 0;
        hold_cycles = 0;
        quiet_phase = 0;
        req.valid = 0;
        req.src_addr = 0;
        req.now_ms = 0;
        cfg.valid = 0;
        cfg.index = pslb_pkg::REG_ADDR_BURST;
        cfg.data = 0;
        lim_addr_burst = pslb_pkg::ADDR_BURST_RST;
        lim_addr_period = pslb_pkg::ADDR_PERIOD_RST;
        lim_glob_burst = pslb_pkg::GLOBAL_BURST_RST;
        lim_glob_period = pslb_pkg::GLOBAL_PERIOD_RST;
        for (int i = 0; i < NENT; i++)
        begin
            tab_valid[i] = 1'b0;
            tab_addr[i] = '0;
            tab_last[i] = '0;
            tab_count[i] = '0;
        end
        glob_last = '0;
        glob_count = '0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed table: after reset, extremes, zero burst, zero period, negative interval
        rows = '{
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0000_0000, 32'd0, 1, pslb_pkg::VERDICT_OK},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'hFFFF_FFFF, 32'd0, 1, pslb_pkg::VERDICT_OK},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0000_0000, 32'hFFFF_FFFF, 1,
              pslb_pkg::VERDICT_OK},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0000_0000, 32'h7FFF_FFFF, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'hAAAA_5555, 32'h8000_0000, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h5555_AAAA, 32'h8000_0001, 0, 0},
            '{1, pslb_pkg::REG_ADDR_BURST, 16'd0, 0, 0, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0A00_0001, 32'h8000_0002, 1,
              pslb_pkg::VERDICT_ADDR},
            '{1, pslb_pkg::REG_ADDR_BURST, 16'd1, 0, 0, 0, 0},
            '{1, pslb_pkg::REG_ADDR_PERIOD, 16'd0, 0, 0, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0A00_0002, 32'h8000_0010, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0A00_0002, 32'h8000_0010, 1,
              pslb_pkg::VERDICT_ADDR},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0A00_0002, 32'h8000_0011, 0, 0},
            '{1, pslb_pkg::REG_GLOBAL_BURST, 16'd0, 0, 0, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0A00_0003, 32'h8000_0100, 1,
              pslb_pkg::VERDICT_SHARED},
            '{1, pslb_pkg::REG_GLOBAL_BURST, 16'd255, 0, 0, 0, 0},
            '{1, pslb_pkg::REG_GLOBAL_PERIOD, 16'd65535, 0, 0, 0, 0},
            '{1, pslb_pkg::REG_ADDR_PERIOD, 16'd65535, 0, 0, 0, 0},
            '{1, pslb_pkg::REG_ADDR_BURST, 16'd255, 0, 0, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0A00_0003, 32'h8000_0200, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'h0A00_0003, 32'h0000_0100, 0, 0},
            '{0, pslb_pkg::REG_ADDR_BURST, 0, 32'hC0A8_0101, 32'h0000_0101, 0, 0}
        };
        foreach (rows[r])
        begin
            if (rows[r].is_cfg)
            begin
                drain();
                write_reg(rows[r].index, rows[r].data);
            end
            else
                send_request(rows[r].addr, rows[r].now, rows[r].known, rows[r].verdict);
        end
        drain();

        // Random phases with varied settings, time advancing mostly forward
        now = 32'h0000_2000;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(pslb_pkg::REG_ADDR_BURST, 16'd3);
                    write_reg(pslb_pkg::REG_ADDR_PERIOD, 16'd50);
                    write_reg(pslb_pkg::REG_GLOBAL_BURST, 16'd8);
                    write_reg(pslb_pkg::REG_GLOBAL_PERIOD, 16'd10);
                end
                1:
                begin
                    write_reg(pslb_pkg::REG_ADDR_BURST, 16'd1);
                    write_reg(pslb_pkg::REG_ADDR_PERIOD, 16'd1);
                    write_reg(pslb_pkg::REG_GLOBAL_BURST, 16'd1);
                    write_reg(pslb_pkg::REG_GLOBAL_PERIOD, 16'd1);
                end
                2:
                begin
                    write_reg(pslb_pkg::REG_ADDR_BURST, 16'd255);
                    write_reg(pslb_pkg::REG_ADDR_PERIOD, 16'd65535);
                    write_reg(pslb_pkg::REG_GLOBAL_BURST, 16'd255);
                    write_reg(pslb_pkg::REG_GLOBAL_PERIOD, 16'd65535);
                end
                default:
                begin
                    write_reg(pslb_pkg::REG_ADDR_BURST, 16'($urandom_range(0, 20)));
                    write_reg(pslb_pkg::REG_ADDR_PERIOD, 16'($urandom_range(0, 300)));
                    write_reg(pslb_pkg::REG_GLOBAL_BURST, 16'($urandom_range(0, 30)));
                    write_reg(pslb_pkg::REG_GLOBAL_PERIOD, 16'($urandom_range(0, 60)));
                end
            endcase
            address_pool.delete();
            pool_size = (ph == 2) ? 300 : int'($urandom_range(4, 40));
            for (int k = 0; k < pool_size; k++)
                address_pool = {address_pool, 32'($urandom())};
            quiet_phase = (ph == 7);
            phase_items = (ph == 2) ? 280 : 165;
            for (int n = 0; n < phase_items; n++)
            begin
                if (ph == 3 && n == 20)
                    hold_cycles = 3000;
                if (ph == 4 && n == 50)
                    drain();
                case ($urandom_range(0, 19))
                    0: now = $urandom();
                    1: now = now - $urandom_range(1, 100);
                    default: now = now + $urandom_range(0, (ph == 2) ? 3 : 40);
                endcase
                if (ph == 2)
                    addr = address_pool[n];
                else if ($urandom_range(0, 9) == 0)
                    addr = $urandom();
                else
                    addr = address_pool[$urandom_range(0, address_pool.size() - 1)];
                send_request(addr, now, 1'b0, pslb_pkg::VERDICT_OK);
            end
            drain();
        end

        if (error_count == 0)
            $display("per_source_leaky_bucket_limiter_top test passed");
        else
            $display("per_source_leaky_bucket_limiter_top test failed");
        $finish;
    end

endmodule

### sim.f
sv/pslb_pkg.sv
sv/pslb_if.sv
sv/pslb_cell.sv
sv/pslb_div.sv
sv/per_source_leaky_bucket_limiter_top.sv
test/per_source_leaky_bucket_limiter_top_tb.sv
